[hw/rtl/rtufrc_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the RTU
// frame receiver and classifier. No dependencies.
package rtufrc_pkg;

  // Default frame store capacity in bytes
  localparam int FRAME_CAPACITY_DEF = 256;

  localparam int HDR_BYTES   = 7;
  localparam int SILENCE_W   = 20;

  localparam logic [SILENCE_W-1:0] SILENCE_RESET = 20'd4009;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX   = 20'hFFFFF;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Function code fields
  localparam logic [7:0] FC_EXC_FLAG       = 8'h80;
  localparam logic [7:0] FC_CODE_MASK      = 8'h7F;
  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_READ_INPUT     = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;

  typedef enum logic [1:0] {
    KIND_UNKNOWN   = 2'd0,
    KIND_REQUEST   = 2'd1,
    KIND_REPLY     = 2'd2,
    KIND_EXCEPTION = 2'd3
  } frame_kind_t;

  // Frame state seen by the classifier
  typedef struct packed {
    logic [15:0]                crc;
    logic [HDR_BYTES-1:0][7:0]  header;
  } trk_snap_t;

  // One classification result
  typedef struct packed {
    logic        frame_ok;
    frame_kind_t frame_kind;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;
    logic [7:0]  exception_code;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [7:0]  data_byte_count;
    logic [8:0]  frame_length;
  } result_t;

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/rtufrc_intf.sv]
// Valid/ready channel interfaces for the RTU frame receiver: input beats,
// result beats and the silence register write channel. Uses rtufrc_pkg.
interface rtufrc_in_if
  import rtufrc_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface rtufrc_out_if
  import rtufrc_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [1:0]  frame_kind;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [7:0]  exception_code;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic [7:0]  data_byte_count;
  logic [8:0]  frame_length;

  modport source (output valid, output frame_ok, output frame_kind, output unit_id,
                  output function_code, output exception_code, output first_word,
                  output second_word, output data_byte_count, output frame_length,
                  input ready);
  modport sink   (input valid, input frame_ok, input frame_kind, input unit_id,
                  input function_code, input exception_code, input first_word,
                  input second_word, input data_byte_count, input frame_length,
                  output ready);
endinterface

interface rtufrc_cfg_if
  import rtufrc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [SILENCE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rtufrc_tracker.sv]
// Frame state tracker: open flag, silence counter, length, running CRC and
// header bytes. Flags the tick that closes a frame. Uses rtufrc_pkg.
module rtufrc_tracker
  import rtufrc_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic                                  command,
  input  logic [7:0]                            rx_byte,
  input  logic [SILENCE_W-1:0]                  silence_ticks,
  output logic                                  close,
  output logic [$clog2(FRAME_CAPACITY+1)-1:0]   len,
  output trk_snap_t                             snap
);

  localparam int LEN_W = $clog2(FRAME_CAPACITY + 1);

  logic                      open, open_next;
  logic [LEN_W-1:0]          len_next;
  logic [15:0]               crc, crc_next;
  logic [SILENCE_W-1:0]      cnt, cnt_next, cnt_inc;
  logic [HDR_BYTES-1:0][7:0] header;
  logic [LEN_W-1:0]          base_len;
  logic [15:0]               base_crc;
  logic                      store_byte;
  logic                      hdr_we;

  // A byte while idle starts from an empty frame
  assign base_len   = open ? len : '0;
  assign base_crc   = open ? crc : CRC_INIT;
  assign store_byte = (base_len < LEN_W'(FRAME_CAPACITY));
  assign hdr_we     = step && (command == CMD_BYTE) && (base_len < LEN_W'(HDR_BYTES));

  // Saturating silence count and close detect
  assign cnt_inc = (cnt == SILENCE_MAX) ? cnt : cnt + 1'b1;
  assign close   = (command == CMD_TICK) && open && (cnt_inc >= silence_ticks);

  always_comb begin
    open_next = open;
    len_next  = len;
    crc_next  = crc;
    cnt_next  = cnt;
    if (step) begin
      if (command == CMD_BYTE) begin
        open_next = 1'b1;
        cnt_next  = '0;
        len_next  = base_len;
        crc_next  = base_crc;
        if (store_byte) begin
          len_next = base_len + 1'b1;
          crc_next = crc16_byte(base_crc, rx_byte);
        end
      end else if (open) begin
        if (close) begin
          open_next = 1'b0;
          len_next  = '0;
          crc_next  = CRC_INIT;
          cnt_next  = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open <= 1'b0;
      len  <= '0;
      crc  <= CRC_INIT;
      cnt  <= '0;
    end else begin
      open <= open_next;
      len  <= len_next;
      crc  <= crc_next;
      cnt  <= cnt_next;
    end
  end

  // Header store, no reset
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header[base_len[2:0]] <= rx_byte;
    end
  end

  assign snap.crc    = crc;
  assign snap.header = header;

  // A closing tick leaves an empty, idle frame
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    step && close |=> !open && len == '0 && crc == CRC_INIT && cnt == '0)
    else $error("frame state not cleared after close");

  // Length never passes capacity
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(FRAME_CAPACITY))
    else $error("stored length above capacity");

endmodule

[hw/rtl/rtufrc_classifier.sv]
// Frame check and classification from the tracker snapshot: CRC residue,
// length checks and function code decode. Uses rtufrc_pkg.
module rtufrc_classifier
  import rtufrc_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic [$clog2(FRAME_CAPACITY+1)-1:0] len,
  input  trk_snap_t                           snap,
  output result_t                             res
);

  localparam int LEN_W = $clog2(FRAME_CAPACITY + 1);
  localparam int CMP_W = LEN_W + 9;

  logic [CMP_W-1:0] len_x;
  logic [7:0]       fc;
  logic             valid_frame;
  logic             is_len8;
  logic             reply_len_ok;
  logic             multi_len_ok;

  assign len_x        = CMP_W'(len);
  assign fc           = snap.header[1];
  assign valid_frame  = (len_x >= CMP_W'(4)) && (snap.crc == 16'h0000);
  assign is_len8      = (len_x == CMP_W'(8));
  assign reply_len_ok = (len_x == CMP_W'(snap.header[2]) + CMP_W'(5));
  assign multi_len_ok = (len_x >= CMP_W'(9))
                        && (len_x == CMP_W'(snap.header[6]) + CMP_W'(9));

  always_comb begin
    res = '0;
    if (valid_frame) begin
      res.frame_ok      = 1'b1;
      res.unit_id       = snap.header[0];
      res.function_code = fc;
      res.frame_length  = len_x[8:0];
      if (((fc & FC_EXC_FLAG) != 8'h00) && (len_x >= CMP_W'(5))) begin
        // Exception reply
        res.frame_kind     = KIND_EXCEPTION;
        res.function_code  = fc & FC_CODE_MASK;
        res.exception_code = snap.header[2];
      end else begin
        unique case (fc) inside
          FC_READ_HOLDING, FC_READ_INPUT: begin
            if (is_len8) begin
              res.frame_kind  = KIND_REQUEST;
              res.first_word  = {snap.header[2], snap.header[3]};
              res.second_word = {snap.header[4], snap.header[5]};
            end else if (reply_len_ok) begin
              res.frame_kind      = KIND_REPLY;
              res.data_byte_count = snap.header[2];
            end
          end
          FC_WRITE_SINGLE: begin
            if (is_len8) begin
              res.frame_kind  = KIND_REQUEST;
              res.first_word  = {snap.header[2], snap.header[3]};
              res.second_word = {snap.header[4], snap.header[5]};
            end
          end
          FC_WRITE_MULTIPLE: begin
            if (is_len8) begin
              res.frame_kind  = KIND_REPLY;
              res.first_word  = {snap.header[2], snap.header[3]};
              res.second_word = {snap.header[4], snap.header[5]};
            end else if (multi_len_ok) begin
              res.frame_kind      = KIND_REQUEST;
              res.first_word      = {snap.header[2], snap.header[3]};
              res.second_word     = {snap.header[4], snap.header[5]};
              res.data_byte_count = snap.header[6];
            end
          end
          default: begin
            res.frame_kind = KIND_UNKNOWN;
          end
        endcase
      end
    end
  end

endmodule

[hw/rtl/rtu_frame_receiver_classifier_unit.sv]
// Top level of the RTU frame receiver and classifier: input register,
// tracker, classifier and result register. Uses rtufrc_pkg, rtufrc_intf.
// A closing tick passes through the input register, then its result loads the result register.
// Throughput: one input beat per cycle; the result register decouples output.
// Stalls only when a closing tick meets a full, unread result register.
// Reset (rst, synchronous): idle, length 0, CRC 0xFFFF, silence 4009 ticks.
module rtu_frame_receiver_classifier_unit
  import rtufrc_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  rtufrc_in_if.sink    in_ch,
  rtufrc_out_if.source out_ch,
  rtufrc_cfg_if.sink   cfg_ch
);

  localparam int LEN_W = $clog2(FRAME_CAPACITY + 1);

  logic                 s1_valid;
  logic                 s1_cmd;
  logic [7:0]           s1_byte;
  logic                 advance;
  logic                 close;
  logic [LEN_W-1:0]     len;
  trk_snap_t            snap;
  result_t              res;
  logic                 out_valid;
  result_t              out_data;
  logic                 load;
  logic [SILENCE_W-1:0] silence_ticks;

  // Silence register write
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_ticks <= SILENCE_RESET;
    end else if (cfg_ch.valid) begin
      silence_ticks <= cfg_ch.data;
    end
  end

  // Input register
  assign advance     = s1_valid && (!close || !out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd  <= in_ch.command;
      s1_byte <= in_ch.rx_byte;
    end
  end

  rtufrc_tracker #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .command      (s1_cmd),
    .rx_byte      (s1_byte),
    .silence_ticks(silence_ticks),
    .close        (close),
    .len          (len),
    .snap         (snap)
  );

  rtufrc_classifier #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_classifier (
    .len (len),
    .snap(snap),
    .res (res)
  );

  // Result register
  assign load = advance && close;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.frame_ok        = out_data.frame_ok;
  assign out_ch.frame_kind      = out_data.frame_kind;
  assign out_ch.unit_id         = out_data.unit_id;
  assign out_ch.function_code   = out_data.function_code;
  assign out_ch.exception_code  = out_data.exception_code;
  assign out_ch.first_word      = out_data.first_word;
  assign out_ch.second_word     = out_data.second_word;
  assign out_ch.data_byte_count = out_data.data_byte_count;
  assign out_ch.frame_length    = out_data.frame_length;

  // A bad frame reports all fields zero
  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.frame_ok |-> out_data == '0)
    else $error("invalid frame with nonzero fields");

  // Only a checked frame gets a kind
  a_kind_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_kind != KIND_UNKNOWN |-> out_data.frame_ok)
    else $error("classified frame not marked ok");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !load)
    else $error("result register overwritten while stalled");

endmodule
